/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the top RTL file of the midpoint subdivider.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define TMSD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked property that also holds during reset.
`define TMSD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hdl/tmsd_pkg.sv */
// ---------------------------------------------------------------------------
// tmsd_pkg
// Shared types and constants of the triangle midpoint subdivider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmsd_pkg;

  // Texture coordinates are unsigned Q0.16 in every configuration.
  localparam int unsigned TEX_WIDTH = 16;

  // Command from the sequencer to the renormalization unit.
  typedef struct packed {
    logic start;
  } nrm_ctl_t;

  // Status returned by the renormalization unit.
  typedef struct packed {
    logic busy;
    logic done;
  } nrm_stat_t;

endpackage

`default_nettype wire

/* hdl/tmsd_norm.sv */
// ---------------------------------------------------------------------------
// tmsd_norm
// Iterative renormalization of the sum of two unit vectors. One squarer,
// one restoring divider step and one compare are reused for every step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmsd_norm #(
  parameter int unsigned DIR_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tmsd_pkg::nrm_ctl_t                  ctl_i,
  input  wire logic [2:0][DIR_WIDTH-1:0]           a_i,
  input  wire logic [2:0][DIR_WIDTH-1:0]           b_i,
  output tmsd_pkg::nrm_stat_t                      stat_o,
  output logic [2:0][DIR_WIDTH-1:0]                res_o
);

  localparam int unsigned SW  = DIR_WIDTH + 1;     // sum of two components
  localparam int unsigned PW2 = 2 * SW;            // square and L2 width
  localparam int unsigned QW  = 2 * DIR_WIDTH - 1; // scaled ratio width
  localparam int unsigned MW  = DIR_WIDTH - 1;     // magnitude, up to ONE
  localparam int unsigned CW  = $clog2(QW);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_DIV  = 3'd2;
  localparam logic [2:0] N_ROOT = 3'd3;
  localparam logic [2:0] N_DONE = 3'd4;

  logic [2:0]             st_q, st_d;
  logic [1:0]             comp_q, comp_d;
  logic [CW-1:0]          step_q, step_d;
  logic [2:0][SW-1:0]     s_q, s_d;
  logic [2:0][PW2-1:0]    magsq_q, magsq_d;
  logic [PW2-1:0]         l2_q, l2_d;
  logic [PW2-1:0]         r_q, r_d;
  logic [QW-1:0]          q_q, q_d;
  logic [MW-1:0]          m_q, m_d;
  logic [2:0][DIR_WIDTH-1:0] res_q, res_d;

  logic [SW-1:0]          s_cur;
  logic [SW-1:0]          mag;
  logic [PW2-1:0]         magsq_nxt;
  logic [MW-1:0]          trial;
  logic [DIR_WIDTH-1:0]   k_odd;
  logic [SW-1:0]          mul_a;
  logic [PW2-1:0]         prod;
  logic [PW2-1:0]         l2_sum;
  logic [PW2:0]           t_rem;
  logic [PW2:0]           t_sub;
  logic                   ge;
  logic                   pass;
  logic [MW-1:0]          m_fin;
  logic [DIR_WIDTH-1:0]   m_ext;
  logic [DIR_WIDTH-1:0]   res_cur;

  always_comb begin
    case (comp_q)
      2'd0:    s_cur = s_q[0];
      2'd1:    s_cur = s_q[1];
      default: s_cur = s_q[2];
    endcase
    case (comp_q)
      2'd0:    magsq_nxt = magsq_q[1];
      default: magsq_nxt = magsq_q[2];
    endcase
  end

  assign mag    = s_cur[SW-1] ? (~s_cur + SW'(1)) : s_cur;
  assign trial  = m_q | (MW'(1) << step_q);
  assign k_odd  = {trial, 1'b0} - DIR_WIDTH'(1);
  assign mul_a  = (st_q == N_SQ) ? mag : {1'b0, k_odd};
  assign prod   = mul_a * mul_a;
  assign l2_sum = l2_q + prod;

  // Long division of magsq * 4 * ONE^2 by L2, one quotient bit a cycle.
  // The first step takes magsq itself, the rest shift in zeros.
  assign t_rem  = (step_q == '0) ? {1'b0, r_q} : {r_q, 1'b0};
  assign ge     = t_rem >= {1'b0, l2_q};
  assign t_sub  = t_rem - {1'b0, l2_q};

  // Greedy search for the largest m with (2m-1)^2 <= quotient.
  assign pass    = prod <= PW2'(q_q);
  assign m_fin   = pass ? trial : m_q;
  assign m_ext   = {1'b0, m_fin};
  assign res_cur = s_cur[SW-1] ? (~m_ext + DIR_WIDTH'(1)) : m_ext;

  always_comb begin
    st_d    = st_q;
    comp_d  = comp_q;
    step_d  = step_q;
    s_d     = s_q;
    magsq_d = magsq_q;
    l2_d    = l2_q;
    r_d     = r_q;
    q_d     = q_q;
    m_d     = m_q;
    res_d   = res_q;
    case (st_q)
      N_IDLE: begin
        if (ctl_i.start) begin
          for (int i = 0; i < 3; i++) begin
            s_d[i] = {a_i[i][DIR_WIDTH-1], a_i[i]} + {b_i[i][DIR_WIDTH-1], b_i[i]};
          end
          comp_d = 2'd0;
          l2_d   = '0;
          st_d   = N_SQ;
        end
      end
      N_SQ: begin
        magsq_d[comp_q] = prod;
        l2_d            = l2_sum;
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          step_d = '0;
          q_d    = '0;
          r_d    = magsq_q[0];
          if (l2_sum == '0) begin
            res_d = '0;
            st_d  = N_DONE;
          end else begin
            st_d  = N_DIV;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      N_DIV: begin
        r_d = ge ? t_sub[PW2-1:0] : t_rem[PW2-1:0];
        q_d = {q_q[QW-2:0], ge};
        if (step_q == CW'(QW - 1)) begin
          step_d = CW'(MW - 1);
          m_d    = '0;
          st_d   = N_ROOT;
        end else begin
          step_d = step_q + CW'(1);
        end
      end
      N_ROOT: begin
        m_d = m_fin;
        if (step_q == '0) begin
          res_d[comp_q] = res_cur;
          if (comp_q == 2'd2) begin
            st_d = N_DONE;
          end else begin
            comp_d = comp_q + 2'd1;
            r_d    = magsq_nxt;
            q_d    = '0;
            st_d   = N_DIV;
          end
        end else begin
          step_d = step_q - CW'(1);
        end
      end
      N_DONE: begin
        st_d = N_IDLE;
      end
      default: begin
        st_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      comp_q <= 2'd0;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      comp_q <= comp_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    magsq_q <= magsq_d;
    l2_q    <= l2_d;
    r_q     <= r_d;
    q_q     <= q_d;
    m_q     <= m_d;
    res_q   <= res_d;
  end

  assign stat_o.busy = st_q != N_IDLE;
  assign stat_o.done = st_q == N_DONE;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* hdl/triangle_midpoint_subdivider.sv */
// ---------------------------------------------------------------------------
// triangle_midpoint_subdivider
// 1-to-4 midpoint subdivision of triangles streamed one vertex at a time.
// ---------------------------------------------------------------------------
// Vertices enter on the input channel (in_valid_i / in_stall_o), three per
// triangle. Each transaction carries one corner: position, normal, tangent
// and texture coordinate. Each corner of a triangle is stored as it is
// taken, and the third corner also starts the output sequence of
// six vertices on the output channel (out_valid_o / out_stall_i): the three
// corners, then the midpoints of v0v1, v1v2 and v0v2. last_of_triangle_o
// marks the sixth. The consumer applies the index pattern itself.
// Midpoint normal and tangent are renormalized by one shared iterative unit
// that squares, divides one quotient bit a cycle and searches one result
// bit a cycle. It renormalizes six directions per triangle, one after
// another, and skips the division and search when the sum is zero, giving
// a zero result. The input is stalled from the third corner until the last
// midpoint has been loaded.
// A stall on the output holds the output register and pauses the sequence.
// Reset clears the corner count and the output valid; stored corners are
// simply overwritten by the next triangle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module triangle_midpoint_subdivider #(
  parameter int unsigned POS_WIDTH = 24,
  parameter int unsigned DIR_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [POS_WIDTH-1:0]           pos_x_i,
  input  wire logic signed [POS_WIDTH-1:0]           pos_y_i,
  input  wire logic signed [POS_WIDTH-1:0]           pos_z_i,
  input  wire logic signed [DIR_WIDTH-1:0]           nrm_x_i,
  input  wire logic signed [DIR_WIDTH-1:0]           nrm_y_i,
  input  wire logic signed [DIR_WIDTH-1:0]           nrm_z_i,
  input  wire logic signed [DIR_WIDTH-1:0]           tan_x_i,
  input  wire logic signed [DIR_WIDTH-1:0]           tan_y_i,
  input  wire logic signed [DIR_WIDTH-1:0]           tan_z_i,
  input  wire logic [tmsd_pkg::TEX_WIDTH-1:0]        tex_u_i,
  input  wire logic [tmsd_pkg::TEX_WIDTH-1:0]        tex_v_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [POS_WIDTH-1:0]                out_pos_x_o,
  output logic signed [POS_WIDTH-1:0]                out_pos_y_o,
  output logic signed [POS_WIDTH-1:0]                out_pos_z_o,
  output logic signed [DIR_WIDTH-1:0]                out_nrm_x_o,
  output logic signed [DIR_WIDTH-1:0]                out_nrm_y_o,
  output logic signed [DIR_WIDTH-1:0]                out_nrm_z_o,
  output logic signed [DIR_WIDTH-1:0]                out_tan_x_o,
  output logic signed [DIR_WIDTH-1:0]                out_tan_y_o,
  output logic signed [DIR_WIDTH-1:0]                out_tan_z_o,
  output logic [tmsd_pkg::TEX_WIDTH-1:0]             out_tex_u_o,
  output logic [tmsd_pkg::TEX_WIDTH-1:0]             out_tex_v_o,
  output logic                                       last_of_triangle_o
);

  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned DW = DIR_WIDTH;
  localparam int unsigned TW = tmsd_pkg::TEX_WIDTH;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CORNER  = 3'd1;
  localparam logic [2:0] S_NRM     = 3'd2;
  localparam logic [2:0] S_NRM_W   = 3'd3;
  localparam logic [2:0] S_TAN     = 3'd4;
  localparam logic [2:0] S_TAN_W   = 3'd5;
  localparam logic [2:0] S_MID_OUT = 3'd6;

  logic [2:0] st_q, st_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  // Stored corners of the current triangle.
  logic [2:0][PW-1:0] c0_pos_q, c1_pos_q, c2_pos_q;
  logic [2:0][DW-1:0] c0_nrm_q, c1_nrm_q, c2_nrm_q;
  logic [2:0][DW-1:0] c0_tan_q, c1_tan_q, c2_tan_q;
  logic [1:0][TW-1:0] c0_tex_q, c1_tex_q, c2_tex_q;

  logic [2:0][DW-1:0] mid_nrm_q, mid_nrm_d;

  logic [2:0][PW-1:0] opos_q, opos_d;
  logic [2:0][DW-1:0] onrm_q, onrm_d;
  logic [2:0][DW-1:0] otan_q, otan_d;
  logic [1:0][TW-1:0] otex_q, otex_d;
  logic               olast_q, olast_d;

  logic [2:0][PW-1:0] in_pos;
  logic [2:0][DW-1:0] in_nrm, in_tan;
  logic [1:0][TW-1:0] in_tex;

  logic [2:0][PW-1:0] pa_pos, pb_pos, sel_pos, mid_pos;
  logic [2:0][DW-1:0] pa_nrm, pb_nrm, pa_tan, pb_tan, sel_nrm, sel_tan;
  logic [1:0][TW-1:0] pa_tex, pb_tex, sel_tex, mid_tex;
  logic [PW:0]        psum [3];
  logic [TW:0]        tsum [2];

  logic               in_acc;
  logic               slot_free;

  tmsd_pkg::nrm_ctl_t  nrm_ctl;
  tmsd_pkg::nrm_stat_t nrm_stat;
  logic [2:0][DW-1:0]  nrm_a, nrm_b, nrm_res;

  assign in_pos = {pos_z_i, pos_y_i, pos_x_i};
  assign in_nrm = {nrm_z_i, nrm_y_i, nrm_x_i};
  assign in_tan = {tan_z_i, tan_y_i, tan_x_i};
  assign in_tex = {tex_v_i, tex_u_i};

  assign in_stall_o = st_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Corner pair of the midpoint in progress: v0v1, v1v2, then v0v2.
  always_comb begin
    case (idx_q)
      2'd0: begin
        pa_pos = c0_pos_q; pa_nrm = c0_nrm_q; pa_tan = c0_tan_q; pa_tex = c0_tex_q;
        pb_pos = c1_pos_q; pb_nrm = c1_nrm_q; pb_tan = c1_tan_q; pb_tex = c1_tex_q;
      end
      2'd1: begin
        pa_pos = c1_pos_q; pa_nrm = c1_nrm_q; pa_tan = c1_tan_q; pa_tex = c1_tex_q;
        pb_pos = c2_pos_q; pb_nrm = c2_nrm_q; pb_tan = c2_tan_q; pb_tex = c2_tex_q;
      end
      default: begin
        pa_pos = c0_pos_q; pa_nrm = c0_nrm_q; pa_tan = c0_tan_q; pa_tex = c0_tex_q;
        pb_pos = c2_pos_q; pb_nrm = c2_nrm_q; pb_tan = c2_tan_q; pb_tex = c2_tex_q;
      end
    endcase
  end

  // Corner passed through during the first three outputs.
  always_comb begin
    case (idx_q)
      2'd0: begin
        sel_pos = c0_pos_q; sel_nrm = c0_nrm_q; sel_tan = c0_tan_q; sel_tex = c0_tex_q;
      end
      2'd1: begin
        sel_pos = c1_pos_q; sel_nrm = c1_nrm_q; sel_tan = c1_tan_q; sel_tex = c1_tex_q;
      end
      default: begin
        sel_pos = c2_pos_q; sel_nrm = c2_nrm_q; sel_tan = c2_tan_q; sel_tex = c2_tex_q;
      end
    endcase
  end

  // Averages round toward minus infinity: drop the low bit of the sum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i]    = {pa_pos[i][PW-1], pa_pos[i]} + {pb_pos[i][PW-1], pb_pos[i]};
      mid_pos[i] = psum[i][PW:1];
    end
    for (int i = 0; i < 2; i++) begin
      tsum[i]    = {1'b0, pa_tex[i]} + {1'b0, pb_tex[i]};
      mid_tex[i] = tsum[i][TW:1];
    end
  end

  // The unit latches its operands on start, so the mux only matters then.
  assign nrm_ctl.start = (st_q == S_NRM) || (st_q == S_TAN);
  assign nrm_a         = (st_q == S_NRM) ? pa_nrm : pa_tan;
  assign nrm_b         = (st_q == S_NRM) ? pb_nrm : pb_tan;

  tmsd_norm #(
    .DIR_WIDTH (DIR_WIDTH)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (nrm_ctl),
    .a_i    (nrm_a),
    .b_i    (nrm_b),
    .stat_o (nrm_stat),
    .res_o  (nrm_res)
  );

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    mid_nrm_d   = mid_nrm_q;
    opos_d      = opos_q;
    onrm_d      = onrm_q;
    otan_d      = otan_q;
    otex_d      = otex_q;
    olast_d     = olast_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q == 2'd0) begin
            cnt_d = 2'd1;
          end else if (cnt_q == 2'd1) begin
            cnt_d = 2'd2;
          end else begin
            cnt_d = 2'd0;
            idx_d = 2'd0;
            st_d  = S_CORNER;
          end
        end
      end
      S_CORNER: begin
        if (slot_free) begin
          opos_d      = sel_pos;
          onrm_d      = sel_nrm;
          otan_d      = sel_tan;
          otex_d      = sel_tex;
          olast_d     = 1'b0;
          out_valid_d = 1'b1;
          if (idx_q == 2'd2) begin
            idx_d = 2'd0;
            st_d  = S_NRM;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      S_NRM: begin
        st_d = S_NRM_W;
      end
      S_NRM_W: begin
        if (nrm_stat.done) begin
          mid_nrm_d = nrm_res;
          st_d      = S_TAN;
        end
      end
      S_TAN: begin
        st_d = S_TAN_W;
      end
      S_TAN_W: begin
        if (nrm_stat.done) begin
          st_d = S_MID_OUT;
        end
      end
      S_MID_OUT: begin
        if (slot_free) begin
          opos_d      = mid_pos;
          onrm_d      = mid_nrm_q;
          otan_d      = nrm_res;
          otex_d      = mid_tex;
          olast_d     = idx_q == 2'd2;
          out_valid_d = 1'b1;
          if (idx_q == 2'd2) begin
            idx_d = 2'd0;
            st_d  = S_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
            st_d  = S_NRM;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= 2'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (cnt_q == 2'd0) begin
        c0_pos_q <= in_pos; c0_nrm_q <= in_nrm; c0_tan_q <= in_tan; c0_tex_q <= in_tex;
      end else if (cnt_q == 2'd1) begin
        c1_pos_q <= in_pos; c1_nrm_q <= in_nrm; c1_tan_q <= in_tan; c1_tex_q <= in_tex;
      end else begin
        c2_pos_q <= in_pos; c2_nrm_q <= in_nrm; c2_tan_q <= in_tan; c2_tex_q <= in_tex;
      end
    end
    mid_nrm_q <= mid_nrm_d;
    opos_q    <= opos_d;
    onrm_q    <= onrm_d;
    otan_q    <= otan_d;
    otex_q    <= otex_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_pos_x_o        = opos_q[0];
  assign out_pos_y_o        = opos_q[1];
  assign out_pos_z_o        = opos_q[2];
  assign out_nrm_x_o        = onrm_q[0];
  assign out_nrm_y_o        = onrm_q[1];
  assign out_nrm_z_o        = onrm_q[2];
  assign out_tan_x_o        = otan_q[0];
  assign out_tan_y_o        = otan_q[1];
  assign out_tan_z_o        = otan_q[2];
  assign out_tex_u_o        = otex_q[0];
  assign out_tex_v_o        = otex_q[1];
  assign last_of_triangle_o = olast_q;

  // A third corner always starts the corner pass-through.
  `TMSD_ASSERT(a_third_starts, clk_i, rst_ni, (in_acc && cnt_q == 2'd2) |=> (st_q == S_CORNER))
  // The renormalization unit is only started while it is idle.
  `TMSD_ASSERT(a_start_idle, clk_i, rst_ni, nrm_ctl.start |-> !nrm_stat.busy)
  // The corner count never reaches its unused code.
  `TMSD_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)

endmodule

`default_nettype wire
